// ===== rtl/core/byte_ring_fifo_with_peek_assert.svh =====
// assertion macros for the byte ring fifo
`ifndef BYTE_RING_FIFO_WITH_PEEK_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_PEEK_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BRFP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BRFP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/brfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brfp_pkg;

	localparam int DEPTH     = 64;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int SIZE_W    = $clog2(DEPTH + 1);
	localparam int DATA_W    = 8;
	localparam int OP_W      = 3;
	localparam int OFF_W     = 16;
	localparam int MOD_W     = OFF_W + 1;
	localparam int MOD_CNT_W = $clog2(MOD_W + 1);
	localparam int BND_W     = (SIZE_W > DATA_W) ? SIZE_W : DATA_W;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_FILL  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_PEEK  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MOD_SEL_HEAD,
		MOD_SEL_TAIL,
		MOD_SEL_PEEK
	} mod_sel_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_OK,
		RES_FAIL,
		RES_WRITE,
		RES_READ,
		RES_HELD,
		RES_HELD_LAST
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_NORM_HEAD,
		ST_NORM_TAIL,
		ST_READ_OUT,
		ST_PK_WAIT,
		ST_PK_ISSUE,
		ST_PK_RUN,
		ST_PK_FLUSH
	} state_t;

	typedef struct packed {
		logic     latch_item;
		logic     mod_start;
		mod_sel_t mod_sel;
		logic     store_head;
		logic     store_tail;
		logic     do_write;
		logic     rd_issue;
		logic     do_clear;
		logic     pk_init;
		logic     pk_issue;
		logic     pk_take;
		res_t     res;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic head_pend;
		logic tail_pend;
		logic empty;
		logic mod_done;
		logic bound_zero;
		logic pk_accept;
		logic pk_more;
		logic hold;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/brfp_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring remainder, one dividend bit per cycle
module brfp_mod (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [brfp_pkg::MOD_W-1:0]        dividend,
	input  logic [brfp_pkg::SIZE_W-1:0]       divisor,
	output logic                              done,
	output logic [brfp_pkg::SIZE_W-1:0]       rem
);

	logic [brfp_pkg::MOD_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [brfp_pkg::MOD_W-1:0]     dvd_q;
	logic [brfp_pkg::SIZE_W-1:0]    dvs_q;
	logic [brfp_pkg::SIZE_W-1:0]    rem_q;
	logic [brfp_pkg::SIZE_W:0]      trial;
	logic [brfp_pkg::SIZE_W:0]      step_rem;

	assign trial    = {rem_q, dvd_q[brfp_pkg::MOD_W-1]};
	assign step_rem = (trial >= {1'b0, dvs_q}) ? (trial - {1'b0, dvs_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == brfp_pkg::MOD_CNT_W'(1));
			if (start) begin
				cnt_q <= brfp_pkg::MOD_CNT_W'(brfp_pkg::MOD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			// remainder stays below the divisor, top bit is always clear
			rem_q <= step_rem[brfp_pkg::SIZE_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/brfp_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brfp_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  brfp_pkg::cmd_t                         cmd,
	output brfp_pkg::status_t                      sts,
	input  logic [brfp_pkg::OP_W-1:0]              opcode,
	input  logic [brfp_pkg::DATA_W-1:0]            data_in,
	input  logic                                   write_last,
	input  logic [brfp_pkg::DATA_W-1:0]            position,
	input  logic signed [brfp_pkg::OFF_W-1:0]      offset,
	input  logic [brfp_pkg::DATA_W-1:0]            peek_length,
	input  logic [brfp_pkg::DATA_W-1:0]            delimiter,
	input  logic [brfp_pkg::DATA_W-1:0]            dest_limit,
	input  logic                                   cfg_we,
	input  logic [brfp_pkg::SIZE_W-1:0]            cfg_wdata,
	output logic                                   done,
	output logic [brfp_pkg::DATA_W-1:0]            data_out,
	output logic                                   byte_valid,
	output logic                                   status,
	output logic [brfp_pkg::SIZE_W-1:0]            fill_level,
	output logic                                   overflow_flag,
	output logic [brfp_pkg::SIZE_W-1:0]            count,
	output logic                                   last
);

	function automatic logic [brfp_pkg::SIZE_W-1:0] eff_size(
		input logic [brfp_pkg::SIZE_W-1:0] qs
	);
		if (qs == '0) begin
			return brfp_pkg::SIZE_W'(1);
		end else if (qs > brfp_pkg::SIZE_W'(brfp_pkg::DEPTH)) begin
			return brfp_pkg::SIZE_W'(brfp_pkg::DEPTH);
		end else begin
			return qs;
		end
	endfunction

	function automatic logic [brfp_pkg::ADDR_W-1:0] next_idx(
		input logic [brfp_pkg::ADDR_W-1:0] idx,
		input logic [brfp_pkg::SIZE_W-1:0] sz
	);
		logic [brfp_pkg::SIZE_W-1:0] inc;
		inc = brfp_pkg::SIZE_W'(idx) + brfp_pkg::SIZE_W'(1);
		return (inc == sz) ? '0 : inc[brfp_pkg::ADDR_W-1:0];
	endfunction

	// queue state
	logic [brfp_pkg::ADDR_W-1:0]  head_q;
	logic [brfp_pkg::ADDR_W-1:0]  tail_q;
	logic [brfp_pkg::SIZE_W-1:0]  held_q;
	logic                         ovf_q;
	logic                         bfail_q;
	logic [brfp_pkg::SIZE_W-1:0]  qsize_q;
	logic                         head_pend_q;
	logic                         tail_pend_q;
	logic [brfp_pkg::DEPTH-1:0]   entry_vld_q;
	logic [brfp_pkg::DATA_W-1:0]  store_q [brfp_pkg::DEPTH];

	// item fields
	brfp_pkg::op_t                 op_q;
	logic [brfp_pkg::DATA_W-1:0]   din_q;
	logic                          wlast_q;
	logic [brfp_pkg::DATA_W-1:0]   pos_q;
	logic signed [brfp_pkg::OFF_W-1:0] off_q;
	logic [brfp_pkg::DATA_W-1:0]   plen_q;
	logic [brfp_pkg::DATA_W-1:0]   delim_q;
	logic [brfp_pkg::DATA_W-1:0]   dlim_q;

	// peek walk
	logic [brfp_pkg::ADDR_W-1:0]  addr_q;
	logic [brfp_pkg::SIZE_W-1:0]  n_q;
	logic                         hold_q;
	logic [brfp_pkg::DATA_W-1:0]  hold_data_q;

	// memory read stage
	logic [brfp_pkg::DATA_W-1:0]  rd_data_s1;
	logic                         rd_vld_s1;

	// result
	logic                         res_valid_q;
	logic [brfp_pkg::DATA_W-1:0]  data_out_q;
	logic                         byte_valid_q;
	logic                         status_q;
	logic [brfp_pkg::SIZE_W-1:0]  count_q;
	logic                         last_q;

	logic [brfp_pkg::SIZE_W-1:0]  esize;
	logic                         wr_fail;
	logic                         full;
	logic                         wr_en;
	logic                         rd_en;
	logic [brfp_pkg::ADDR_W-1:0]  rd_addr;
	logic [brfp_pkg::DATA_W-1:0]  rd_byte;
	logic signed [brfp_pkg::MOD_W-1:0] sum_c;
	logic                         sum_neg;
	logic [brfp_pkg::MOD_W-1:0]   sum_mag;
	logic [brfp_pkg::MOD_W-1:0]   mod_dvd;
	logic                         mod_done;
	logic [brfp_pkg::SIZE_W-1:0]  mod_rem;
	logic [brfp_pkg::SIZE_W-1:0]  pk_start_full;
	logic [brfp_pkg::ADDR_W-1:0]  pk_start;
	logic                         counted;
	logic [brfp_pkg::BND_W-1:0]   plen_b;
	logic [brfp_pkg::BND_W-1:0]   dlim_b;
	logic [brfp_pkg::BND_W-1:0]   size_b;
	logic [brfp_pkg::BND_W-1:0]   bound_c;

	assign esize   = eff_size(qsize_q);
	assign full    = held_q >= esize;
	assign wr_fail = bfail_q || full;
	assign wr_en   = cmd.do_write && !wr_fail;
	assign rd_en   = cmd.rd_issue || cmd.pk_issue;
	assign rd_addr = cmd.pk_issue ? addr_q : head_q;
	assign rd_byte = rd_vld_s1 ? rd_data_s1 : '0;

	// position plus signed offset, true modulo built from magnitude remainder
	assign sum_c   = $signed({{(brfp_pkg::MOD_W - brfp_pkg::DATA_W){1'b0}}, pos_q})
	               + $signed({off_q[brfp_pkg::OFF_W-1], off_q});
	assign sum_neg = sum_c[brfp_pkg::MOD_W-1];
	assign sum_mag = sum_neg ? (~sum_c + brfp_pkg::MOD_W'(1)) : sum_c;

	always_comb begin
		unique case (cmd.mod_sel)
			brfp_pkg::MOD_SEL_HEAD: mod_dvd = brfp_pkg::MOD_W'(head_q);
			brfp_pkg::MOD_SEL_TAIL: mod_dvd = brfp_pkg::MOD_W'(tail_q);
			brfp_pkg::MOD_SEL_PEEK: mod_dvd = sum_mag;
			default:                mod_dvd = '0;
		endcase
	end

	brfp_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mod_dvd),
		.divisor  (esize),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign pk_start_full = (sum_neg && mod_rem != '0) ? (esize - mod_rem) : mod_rem;
	assign pk_start      = pk_start_full[brfp_pkg::ADDR_W-1:0];

	// counted run or delimiter run, and how many bytes it may take
	assign plen_b  = brfp_pkg::BND_W'(plen_q);
	assign dlim_b  = brfp_pkg::BND_W'(dlim_q);
	assign size_b  = brfp_pkg::BND_W'(esize);
	assign counted = (plen_q != '0) && (plen_b < size_b);

	always_comb begin
		if (counted) begin
			bound_c = (plen_b < dlim_b) ? plen_b : dlim_b;
		end else if (delim_q == '0) begin
			bound_c = '0;
		end else begin
			bound_c = (dlim_b < size_b) ? dlim_b : size_b;
		end
	end

	always_comb begin
		sts.op         = op_q;
		// a pointer is reduced only right before the item that uses it
		sts.head_pend  = head_pend_q && (op_q == brfp_pkg::OP_READ) && (held_q != '0);
		sts.tail_pend  = tail_pend_q && (op_q == brfp_pkg::OP_WRITE) && !wr_fail;
		sts.empty      = (held_q == '0);
		sts.mod_done   = mod_done;
		sts.bound_zero = (bound_c == '0);
		sts.pk_accept  = counted || (rd_byte != delim_q);
		sts.pk_more    = (brfp_pkg::BND_W'(n_q) + brfp_pkg::BND_W'(1)) < bound_c;
		sts.hold       = hold_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			held_q      <= '0;
			ovf_q       <= 1'b0;
			bfail_q     <= 1'b0;
			qsize_q     <= brfp_pkg::SIZE_W'(brfp_pkg::DEPTH);
			head_pend_q <= 1'b0;
			tail_pend_q <= 1'b0;
			entry_vld_q <= '0;
			n_q         <= '0;
			hold_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (cmd.res != brfp_pkg::RES_NONE);
			if (cmd.store_head) begin
				head_q      <= mod_rem[brfp_pkg::ADDR_W-1:0];
				head_pend_q <= 1'b0;
			end
			if (cmd.store_tail) begin
				tail_q      <= mod_rem[brfp_pkg::ADDR_W-1:0];
				tail_pend_q <= 1'b0;
			end
			// each pointer is reduced against the new size before its next use
			if (cfg_we) begin
				qsize_q     <= cfg_wdata;
				head_pend_q <= 1'b1;
				tail_pend_q <= 1'b1;
			end
			if (cmd.do_write) begin
				if (bfail_q) begin
					if (wlast_q) begin
						bfail_q <= 1'b0;
					end
				end else if (full) begin
					ovf_q   <= 1'b1;
					bfail_q <= !wlast_q;
				end else begin
					entry_vld_q[tail_q] <= 1'b1;
					tail_q              <= next_idx(tail_q, esize);
					held_q              <= held_q + 1'b1;
				end
			end
			if (cmd.rd_issue) begin
				head_q <= next_idx(head_q, esize);
				held_q <= held_q - 1'b1;
			end
			if (cmd.do_clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				held_q  <= '0;
				ovf_q   <= 1'b0;
				bfail_q <= 1'b0;
				for (int i = 0; i < brfp_pkg::DEPTH; i++) begin
					if (brfp_pkg::SIZE_W'(i) < esize) begin
						entry_vld_q[i] <= 1'b0;
					end
				end
			end
			if (cmd.pk_init) begin
				n_q    <= '0;
				hold_q <= 1'b0;
			end
			if (cmd.pk_take) begin
				n_q    <= n_q + 1'b1;
				hold_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[tail_q] <= din_q;
		end
		if (rd_en) begin
			rd_data_s1 <= store_q[rd_addr];
			rd_vld_s1  <= entry_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			op_q    <= brfp_pkg::op_t'(opcode);
			din_q   <= data_in;
			wlast_q <= write_last;
			pos_q   <= position;
			off_q   <= offset;
			plen_q  <= peek_length;
			delim_q <= delimiter;
			dlim_q  <= dest_limit;
		end
		if (cmd.pk_init) begin
			addr_q <= pk_start;
		end
		if (cmd.pk_issue) begin
			addr_q <= next_idx(addr_q, esize);
		end
		if (cmd.pk_take) begin
			hold_data_q <= rd_byte;
		end
		unique case (cmd.res)
			brfp_pkg::RES_NONE: begin
			end
			brfp_pkg::RES_OK, brfp_pkg::RES_FAIL, brfp_pkg::RES_WRITE: begin
				data_out_q   <= '0;
				byte_valid_q <= 1'b0;
				status_q     <= (cmd.res == brfp_pkg::RES_FAIL) ||
				                ((cmd.res == brfp_pkg::RES_WRITE) && wr_fail);
				count_q      <= '0;
				last_q       <= 1'b1;
			end
			brfp_pkg::RES_READ: begin
				data_out_q   <= rd_byte;
				byte_valid_q <= 1'b1;
				status_q     <= 1'b0;
				count_q      <= '0;
				last_q       <= 1'b1;
			end
			brfp_pkg::RES_HELD, brfp_pkg::RES_HELD_LAST: begin
				data_out_q   <= hold_data_q;
				byte_valid_q <= 1'b1;
				status_q     <= 1'b0;
				count_q      <= (cmd.res == brfp_pkg::RES_HELD_LAST) ? n_q : '0;
				last_q       <= (cmd.res == brfp_pkg::RES_HELD_LAST);
			end
			default: begin
			end
		endcase
	end

	assign done          = res_valid_q;
	assign data_out      = data_out_q;
	assign byte_valid    = byte_valid_q;
	assign status        = status_q;
	assign fill_level    = held_q;
	assign overflow_flag = ovf_q;
	assign count         = count_q;
	assign last          = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/brfp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  brfp_pkg::status_t sts,
	output brfp_pkg::cmd_t    cmd
);

	brfp_pkg::state_t state_q;
	brfp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brfp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			brfp_pkg::ST_IDLE: begin
				if (start) state_d = brfp_pkg::ST_DISPATCH;
			end
			brfp_pkg::ST_DISPATCH: begin
				if (sts.head_pend) begin
					state_d = brfp_pkg::ST_NORM_HEAD;
				end else if (sts.tail_pend) begin
					state_d = brfp_pkg::ST_NORM_TAIL;
				end else begin
					unique case (sts.op)
						brfp_pkg::OP_READ:
							state_d = sts.empty ? brfp_pkg::ST_IDLE : brfp_pkg::ST_READ_OUT;
						brfp_pkg::OP_PEEK: state_d = brfp_pkg::ST_PK_WAIT;
						default:           state_d = brfp_pkg::ST_IDLE;
					endcase
				end
			end
			brfp_pkg::ST_NORM_HEAD: begin
				if (sts.mod_done) state_d = brfp_pkg::ST_DISPATCH;
			end
			brfp_pkg::ST_NORM_TAIL: begin
				if (sts.mod_done) state_d = brfp_pkg::ST_DISPATCH;
			end
			brfp_pkg::ST_READ_OUT: state_d = brfp_pkg::ST_IDLE;
			brfp_pkg::ST_PK_WAIT: begin
				if (sts.mod_done) begin
					state_d = sts.bound_zero ? brfp_pkg::ST_IDLE : brfp_pkg::ST_PK_ISSUE;
				end
			end
			brfp_pkg::ST_PK_ISSUE: state_d = brfp_pkg::ST_PK_RUN;
			brfp_pkg::ST_PK_RUN: begin
				if (!sts.pk_accept) begin
					state_d = brfp_pkg::ST_IDLE;
				end else if (!sts.pk_more) begin
					state_d = brfp_pkg::ST_PK_FLUSH;
				end
			end
			brfp_pkg::ST_PK_FLUSH: state_d = brfp_pkg::ST_IDLE;
			default:               state_d = brfp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.mod_sel = brfp_pkg::MOD_SEL_HEAD;
		cmd.res     = brfp_pkg::RES_NONE;
		busy        = (state_q != brfp_pkg::ST_IDLE);
		unique case (state_q)
			brfp_pkg::ST_IDLE: begin
				cmd.latch_item = start;
			end
			brfp_pkg::ST_DISPATCH: begin
				if (sts.head_pend) begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = brfp_pkg::MOD_SEL_HEAD;
				end else if (sts.tail_pend) begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = brfp_pkg::MOD_SEL_TAIL;
				end else begin
					unique case (sts.op)
						brfp_pkg::OP_WRITE: begin
							cmd.do_write = 1'b1;
							cmd.res      = brfp_pkg::RES_WRITE;
						end
						brfp_pkg::OP_READ: begin
							if (sts.empty) begin
								cmd.res = brfp_pkg::RES_FAIL;
							end else begin
								cmd.rd_issue = 1'b1;
							end
						end
						brfp_pkg::OP_FILL: begin
							cmd.res = brfp_pkg::RES_OK;
						end
						brfp_pkg::OP_CLEAR: begin
							cmd.do_clear = 1'b1;
							cmd.res      = brfp_pkg::RES_OK;
						end
						brfp_pkg::OP_PEEK: begin
							cmd.mod_start = 1'b1;
							cmd.mod_sel   = brfp_pkg::MOD_SEL_PEEK;
						end
						default: begin
							cmd.res = brfp_pkg::RES_FAIL;
						end
					endcase
				end
			end
			brfp_pkg::ST_NORM_HEAD: begin
				cmd.store_head = sts.mod_done;
			end
			brfp_pkg::ST_NORM_TAIL: begin
				cmd.store_tail = sts.mod_done;
			end
			brfp_pkg::ST_READ_OUT: begin
				cmd.res = brfp_pkg::RES_READ;
			end
			brfp_pkg::ST_PK_WAIT: begin
				if (sts.mod_done) begin
					if (sts.bound_zero) begin
						cmd.res = brfp_pkg::RES_OK;
					end else begin
						cmd.pk_init = 1'b1;
					end
				end
			end
			brfp_pkg::ST_PK_ISSUE: begin
				cmd.pk_issue = 1'b1;
			end
			brfp_pkg::ST_PK_RUN: begin
				// one byte is held back so the final beat can carry last and count
				if (sts.pk_accept) begin
					cmd.pk_take  = 1'b1;
					cmd.pk_issue = sts.pk_more;
					if (sts.hold) cmd.res = brfp_pkg::RES_HELD;
				end else begin
					cmd.res = sts.hold ? brfp_pkg::RES_HELD_LAST : brfp_pkg::RES_OK;
				end
			end
			brfp_pkg::ST_PK_FLUSH: begin
				cmd.res = brfp_pkg::RES_HELD_LAST;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_fifo_with_peek.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake
// item      in   start, busy: taken on an edge with start high and busy low
// result    out  done: one beat per cycle it is high, no back-pressure
// config    in   cfg_we, cfg_wdata: queue_size written on any edge with cfg_we
//
// write, fill level, clear, unknown op: answered from dispatch, then back to idle
// read: one registered store read before the answer
// peek: waits on the 17-step remainder, then copies its bytes, if any can be copied
// after a queue_size write, the first read of a non-empty queue and the first write that is not refused
// each first reduce the pointer they use
// async reset clears pointers, count, flags and entry valid bits at once
// done cannot be held off; the beats of one peek come on consecutive cycles

`include "byte_ring_fifo_with_peek_assert.svh"

module byte_ring_fifo_with_peek (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [brfp_pkg::OP_W-1:0]         opcode,
	input  logic [brfp_pkg::DATA_W-1:0]       data_in,
	input  logic                              write_last,
	input  logic [brfp_pkg::DATA_W-1:0]       position,
	input  logic signed [brfp_pkg::OFF_W-1:0] offset,
	input  logic [brfp_pkg::DATA_W-1:0]       peek_length,
	input  logic [brfp_pkg::DATA_W-1:0]       delimiter,
	input  logic [brfp_pkg::DATA_W-1:0]       dest_limit,
	input  logic                              cfg_we,
	input  logic [brfp_pkg::SIZE_W-1:0]       cfg_wdata,
	output logic                              done,
	output logic [brfp_pkg::DATA_W-1:0]       data_out,
	output logic                              byte_valid,
	output logic                              status,
	output logic [brfp_pkg::SIZE_W-1:0]       fill_level,
	output logic                              overflow_flag,
	output logic [brfp_pkg::SIZE_W-1:0]       count,
	output logic                              last
);

	brfp_pkg::cmd_t    cmd;
	brfp_pkg::status_t sts;

	brfp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	brfp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.data_in       (data_in),
		.write_last    (write_last),
		.position      (position),
		.offset        (offset),
		.peek_length   (peek_length),
		.delimiter     (delimiter),
		.dest_limit    (dest_limit),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.data_out      (data_out),
		.byte_valid    (byte_valid),
		.status        (status),
		.fill_level    (fill_level),
		.overflow_flag (overflow_flag),
		.count         (count),
		.last          (last)
	);

	// an accepted item always makes the block busy in the next cycle
	`BRFP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	// the final beat of an item is never directly followed by another beat
	`BRFP_ASSERT_NXT(a_last_gap, done && last, !done, "beat right after a final beat")
	// beats of one peek are back to back
	`BRFP_ASSERT_NXT(a_run_cont, done && !last, done, "gap inside a multi-beat result")
	// a byte count only rides on the final beat of a peek
	`BRFP_ASSERT_IMP(a_count_last, done && count != '0, last && byte_valid,
		"count on a beat that is not a final peek byte")

endmodule

`default_nettype wire

// ===== tb/tb_byte_ring_fifo_with_peek.sv =====
`timescale 1ns / 1ps

module tb_byte_ring_fifo_with_peek;
	import brfp_pkg::*;

	localparam int OP_MAX = (1 << OP_W) - 1;

	typedef struct {
		bit [OP_W-1:0]          opcode;
		bit [DATA_W-1:0]        data_in;
		bit                     write_last;
		bit [DATA_W-1:0]        position;
		bit signed [OFF_W-1:0]  offset;
		bit [DATA_W-1:0]        peek_length;
		bit [DATA_W-1:0]        delimiter;
		bit [DATA_W-1:0]        dest_limit;
	} fifo_item_t;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic              valid;
		logic              status;
		logic [SIZE_W-1:0] fill;
		logic              ovf;
		logic [SIZE_W-1:0] cnt;
		logic              last;
	} fifo_beat_t;

	class ring_tracker;
		bit [DATA_W-1:0] store [DEPTH];
		int              head;
		int              tail;
		int              held;
		bit              ovf;
		bit              burst_bad;
		bit [SIZE_W-1:0] size_reg;
		fifo_beat_t      fifo_beats_due[$];
		int              errors;

		function new();
			foreach (store[i]) store[i] = '0;
			head = 0;
			tail = 0;
			held = 0;
			ovf = 1'b0;
			burst_bad = 1'b0;
			size_reg = 7'd64;
			errors = 0;
		endfunction

		function int eff_size();
			if (size_reg == 0) return 1;
			if (size_reg > DEPTH) return DEPTH;
			return size_reg;
		endfunction

		function void add_beat(bit [DATA_W-1:0] d, bit v, bit st, int cnt, bit lst);
			fifo_beat_t b;
			b.data = d;
			b.valid = v;
			b.status = st;
			b.fill = held[SIZE_W-1:0];
			b.ovf = ovf;
			b.cnt = cnt[SIZE_W-1:0];
			b.last = lst;
			fifo_beats_due.push_back(b);
		endfunction

		function void apply_op(fifo_item_t it);
			int sz;
			int t;
			int sum;
			int m;
			int s;
			int n;
			bit st;
			bit [DATA_W-1:0] copied[$];
			sz = eff_size();
			case (it.opcode)
				OP_WRITE: begin
					st = 1'b0;
					if (burst_bad) begin
						// rest of a failed burst is dropped up to the last byte
						st = 1'b1;
						if (it.write_last) burst_bad = 1'b0;
					end else if (held >= sz) begin
						ovf = 1'b1;
						st = 1'b1;
						burst_bad = !it.write_last;
					end else begin
						t = tail % sz;
						store[t] = it.data_in;
						tail = (t + 1) % sz;
						held++;
					end
					add_beat(0, 0, st, 0, 1);
				end
				OP_READ: begin
					if (held == 0) begin
						add_beat(0, 0, 1, 0, 1);
					end else begin
						t = head % sz;
						head = (t + 1) % sz;
						held--;
						add_beat(store[t], 1, 0, 0, 1);
					end
				end
				OP_FILL: begin
					add_beat(0, 0, 0, 0, 1);
				end
				OP_CLEAR: begin
					for (int i = 0; i < sz; i++) store[i] = '0;
					head = 0;
					tail = 0;
					held = 0;
					ovf = 1'b0;
					burst_bad = 1'b0;
					add_beat(0, 0, 0, 0, 1);
				end
				OP_PEEK: begin
					sum = int'(it.position) + int'(it.offset);
					m = sum % sz;
					if (m < 0) m += sz;
					s = m;
					n = 0;
					if (it.peek_length != 0 && it.peek_length < sz) begin
						n = (it.peek_length < it.dest_limit) ? it.peek_length : it.dest_limit;
						for (int i = 0; i < n; i++) begin
							copied.push_back(store[s]);
							s = (s + 1) % sz;
						end
					end else if (it.delimiter != 0) begin
						while (store[s] != it.delimiter && n < it.dest_limit && n < sz) begin
							copied.push_back(store[s]);
							n++;
							s = (s + 1) % sz;
						end
					end
					if (n == 0) begin
						add_beat(0, 0, 0, 0, 1);
					end else begin
						for (int i = 0; i < n; i++)
							add_beat(copied[i], 1, 0, (i == n - 1) ? n : 0, i == n - 1);
					end
				end
				default: begin
					add_beat(0, 0, 1, 0, 1);
				end
			endcase
		endfunction

		function void field_check(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void compare_beat(fifo_beat_t got);
			fifo_beat_t want;
			if (fifo_beats_due.size() == 0) begin
				$display("%0t: result beat with none expected, expected nothing, actual data_out %0d",
					$time, got.data);
				errors++;
				return;
			end
			want = fifo_beats_due.pop_front();
			field_check("data_out", want.data, got.data);
			field_check("byte_valid", want.valid, got.valid);
			field_check("status", want.status, got.status);
			field_check("fill_level", want.fill, got.fill);
			field_check("overflow_flag", want.ovf, got.ovf);
			field_check("count", want.cnt, got.cnt);
			field_check("last", want.last, got.last);
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [OP_W-1:0]         opcode = '0;
	logic [DATA_W-1:0]       data_in = '0;
	logic                    write_last = 1'b0;
	logic [DATA_W-1:0]       position = '0;
	logic signed [OFF_W-1:0] offset = '0;
	logic [DATA_W-1:0]       peek_length = '0;
	logic [DATA_W-1:0]       delimiter = '0;
	logic [DATA_W-1:0]       dest_limit = '0;
	logic                    cfg_we = 1'b0;
	logic [SIZE_W-1:0]       cfg_wdata = '0;
	logic                    done;
	logic [DATA_W-1:0]       data_out;
	logic                    byte_valid;
	logic                    status;
	logic [SIZE_W-1:0]       fill_level;
	logic                    overflow_flag;
	logic [SIZE_W-1:0]       count;
	logic                    last;

	ring_tracker sb;
	fifo_beat_t  seen_beat;
	bit          no_idle = 1'b0;

	byte_ring_fifo_with_peek u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.data_in       (data_in),
		.write_last    (write_last),
		.position      (position),
		.offset        (offset),
		.peek_length   (peek_length),
		.delimiter     (delimiter),
		.dest_limit    (dest_limit),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.data_out      (data_out),
		.byte_valid    (byte_valid),
		.status        (status),
		.fill_level    (fill_level),
		.overflow_flag (overflow_flag),
		.count         (count),
		.last          (last)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1 && sb != null) begin
			seen_beat.data = data_out;
			seen_beat.valid = byte_valid;
			seen_beat.status = status;
			seen_beat.fill = fill_level;
			seen_beat.ovf = overflow_flag;
			seen_beat.cnt = count;
			seen_beat.last = last;
			sb.compare_beat(seen_beat);
		end
	end

	function automatic fifo_item_t rand_item();
		fifo_item_t it;
		it.opcode = $urandom_range(0, OP_MAX);
		it.data_in = $urandom_range(0, 255);
		it.write_last = $urandom_range(0, 1);
		it.position = $urandom_range(0, 255);
		it.offset = $urandom_range(0, 65535);
		it.peek_length = $urandom_range(0, 255);
		it.delimiter = $urandom_range(0, 255);
		it.dest_limit = $urandom_range(0, 255);
		return it;
	endfunction

	function automatic fifo_item_t plain_item(bit [OP_W-1:0] op, bit [7:0] d, bit lst);
		fifo_item_t it;
		it = rand_item();
		it.opcode = op;
		it.data_in = d;
		it.write_last = lst;
		return it;
	endfunction

	function automatic fifo_item_t peek_item(bit [7:0] pos, int off, bit [7:0] len,
			bit [7:0] delim, bit [7:0] lim);
		fifo_item_t it;
		it = rand_item();
		it.opcode = OP_PEEK;
		it.position = pos;
		it.offset = off;
		it.peek_length = len;
		it.delimiter = delim;
		it.dest_limit = lim;
		return it;
	endfunction

	task automatic send_item(fifo_item_t it);
		int gap;
		if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode <= it.opcode;
		data_in <= it.data_in;
		write_last <= it.write_last;
		position <= it.position;
		offset <= it.offset;
		peek_length <= it.peek_length;
		delimiter <= it.delimiter;
		dest_limit <= it.dest_limit;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		sb.apply_op(it);
	endtask

	// only while idle: all beats in, then a pause for pointer reduction
	task automatic write_queue_size(bit [SIZE_W-1:0] v);
		start <= 1'b0;
		while (sb.fifo_beats_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.size_reg = v;
		cfg_we <= 1'b0;
	endtask

	initial begin
		int         phase_size[10] = '{0, 127, 1, 7, 64, 33, 65, 3, 0, 64};
		bit         phase_clear[10] = '{1, 1, 0, 1, 0, 1, 0, 1, 1, 0};
		fifo_item_t it;
		int         left;
		int         sz;
		int         pick;
		int         len;
		int         drain;
		bit         broken;
		bit [SIZE_W-1:0] cfg_val;

		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset size, empty store of zeros
		send_item(plain_item(OP_FILL, 8'h00, 1'b0));
		send_item(plain_item(OP_READ, 8'h00, 1'b0));
		send_item(peek_item(8'd255, -32768, 8'd0, 8'hFF, 8'd255));
		send_item(peek_item(8'd0, 0, 8'd0, 8'h00, 8'd255));
		send_item(peek_item(8'd10, 5, 8'd1, 8'h12, 8'd0));
		send_item(plain_item(3'(OP_PEEK + 1), 8'h00, 1'b0));
		send_item(plain_item(3'(OP_MAX), 8'hFF, 1'b1));
		send_item(plain_item(OP_WRITE, 8'h00, 1'b1));
		send_item(plain_item(OP_WRITE, 8'hFF, 1'b0));
		send_item(plain_item(OP_WRITE, 8'hA5, 1'b1));
		send_item(peek_item(8'd0, 0, 8'd63, 8'h00, 8'd3));
		// delimiter run that wraps from the top entry
		send_item(peek_item(8'd0, 32767, 8'd0, 8'hA5, 8'd255));
		send_item(peek_item(8'd0, -1, 8'd64, 8'hFF, 8'd255));
		send_item(plain_item(OP_READ, 8'h00, 1'b0));
		send_item(plain_item(OP_READ, 8'h00, 1'b0));
		send_item(plain_item(OP_FILL, 8'h00, 1'b0));
		send_item(plain_item(OP_CLEAR, 8'h00, 1'b0));
		send_item(plain_item(OP_READ, 8'h00, 1'b0));

		// overflow, dropped burst bytes, write at full with last set
		write_queue_size(7'd2);
		send_item(plain_item(OP_WRITE, 8'h11, 1'b0));
		send_item(plain_item(OP_WRITE, 8'h22, 1'b0));
		send_item(plain_item(OP_WRITE, 8'h33, 1'b0));
		send_item(plain_item(OP_WRITE, 8'h44, 1'b1));
		send_item(plain_item(OP_WRITE, 8'h55, 1'b1));
		send_item(plain_item(OP_READ, 8'h00, 1'b0));
		send_item(plain_item(OP_READ, 8'h00, 1'b0));
		send_item(plain_item(OP_READ, 8'h00, 1'b0));
		send_item(peek_item(8'd0, -3, 8'd1, 8'h00, 8'd255));

		for (int p = 0; p < 10; p++) begin
			cfg_val = (p == 8) ? 7'($urandom_range(1, 127)) : 7'(phase_size[p]);
			write_queue_size(cfg_val);
			if (phase_clear[p]) send_item(plain_item(OP_CLEAR, 8'h00, 1'b0));
			left = 41;
			while (left > 0) begin
				sz = sb.eff_size();
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, sz + 3) : $urandom_range(1, 4);
					if (len > left) len = left;
					broken = ($urandom_range(0, 9) == 0);
					for (int k = 0; k < len; k++) begin
						it = plain_item(OP_WRITE, $urandom_range(0, 255), (k == len - 1) && !broken);
						send_item(it);
						left--;
					end
				end else if (pick < 58) begin
					len = $urandom_range(1, sz + 2);
					if (len > left) len = left;
					for (int k = 0; k < len; k++) begin
						send_item(plain_item(OP_READ, $urandom_range(0, 255), $urandom_range(0, 1)));
						left--;
					end
				end else if (pick < 80) begin
					it = rand_item();
					it.opcode = OP_PEEK;
					if ($urandom_range(0, 1)) it.offset = $urandom_range(0, 200) - 100;
					it.dest_limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 8'd255;
					case ($urandom_range(0, 2))
						0: begin
							if (sz > 1) it.peek_length = $urandom_range(1, sz - 1);
						end
						1: begin
							// delimiter taken from the store so the run can stop on it
							it.peek_length = $urandom_range(0, 1) ? 0 : $urandom_range(sz, 255);
							it.delimiter = sb.store[$urandom_range(0, sz - 1)];
						end
						default: ;
					endcase
					send_item(it);
					left--;
				end else if (pick < 88) begin
					send_item(plain_item(OP_FILL, $urandom_range(0, 255), $urandom_range(0, 1)));
					left--;
				end else if (pick < 92) begin
					send_item(plain_item(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1)));
					left--;
				end else begin
					send_item(rand_item());
					left--;
				end
			end
		end

		start <= 1'b0;
		drain = 0;
		while (sb.fifo_beats_due.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.fifo_beats_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule
